[rtl/vteq_pkg.sv]
// ----------------------------------------------------------------------------
// vteq_pkg
// Shared types and result codes for the virtual-time event queue.
// ----------------------------------------------------------------------------
package vteq_pkg;

    localparam logic       OP_SCHEDULE = 1'b0;
    localparam logic       OP_RUN      = 1'b1;

    localparam logic [1:0] KIND_ACCEPTED  = 2'd0;
    localparam logic [1:0] KIND_FULL      = 2'd1;
    localparam logic [1:0] KIND_DELIVERED = 2'd2;
    localparam logic [1:0] KIND_EMPTY     = 2'd3;

    typedef struct packed {
        logic [31:0]        ev_time;
        logic signed [31:0] ev_value;
        logic [7:0]         ev_target;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

[rtl/virtual_time_event_queue.sv]
// ----------------------------------------------------------------------------
// virtual_time_event_queue
// Fixed-size discrete-event queue kept sorted by time in a chain of cells.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Fields
//  command   start, busy            i_op, i_event_time, i_event_value, i_target
//  result    o_valid (one cycle)    o_kind, o_out_time, o_out_value,
//                                   o_out_target, o_last
//
// A schedule command's answer appears the next cycle.
// A run command pops the head cell once per cycle, so it holds busy until it
// pops the last live event and gives one result per cycle, the first in the
// cycle after the command. An empty queue gives a single answer in the cycle
// after the command. Reset empties every cell.
// The receiver cannot stall; every result is shown for exactly one cycle.
module virtual_time_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [31:0]        i_event_time,
    input  logic signed [31:0] i_event_value,
    input  logic [7:0]         i_target,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic [31:0]        o_out_time,
    output logic signed [31:0] o_out_value,
    output logic [7:0]         o_out_target,
    output logic               o_last
);
    import vteq_pkg::*;

    t_entry     w_entry [QUEUE_DEPTH];
    logic       w_valid [QUEUE_DEPTH];
    logic       w_shift [QUEUE_DEPTH];
    t_cell_ctrl w_ctrl;
    t_entry     w_new;
    logic       w_accept;
    logic       w_full;

    logic       r_busy;
    logic       r_out_valid;
    logic [1:0] r_kind;
    t_entry     r_out;
    logic       r_last;

    assign w_accept  = start && !r_busy;
    assign w_full    = w_valid[QUEUE_DEPTH-1];
    assign w_new     = '{ev_time: i_event_time, ev_value: i_event_value,
                         ev_target: i_target};
    assign w_ctrl    = '{ins: w_accept && (i_op == OP_SCHEDULE) && !w_full,
                         pop: r_busy || (w_accept && (i_op == OP_RUN) && w_valid[0])};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_prev_entry;
        logic   w_prev_valid;
        logic   w_prev_shift;
        t_entry w_next_entry;
        logic   w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_entry = '0;
            assign w_prev_valid = 1'b1;
            assign w_prev_shift = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_shift = w_shift[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_entry = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_entry = w_entry[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        vteq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_prev_entry (w_prev_entry),
            .i_prev_valid (w_prev_valid),
            .i_prev_shift (w_prev_shift),
            .i_next_entry (w_next_entry),
            .i_next_valid (w_next_valid),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_shift      (w_shift[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_accept || r_busy;
            if (w_ctrl.pop) begin
                r_busy <= w_valid[1];
            end
        end

        if (w_ctrl.pop) begin
            r_kind <= KIND_DELIVERED;
            r_out  <= w_entry[0];
            r_last <= !w_valid[1];
        end else if (w_accept) begin
            r_out  <= '0;
            r_last <= 1'b1;
            if (i_op == OP_RUN) begin
                r_kind <= KIND_EMPTY;
            end else if (w_full) begin
                r_kind <= KIND_FULL;
            end else begin
                r_kind <= KIND_ACCEPTED;
            end
        end
    end

    assign busy         = r_busy;
    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_time   = r_out.ev_time;
    assign o_out_value  = r_out.ev_value;
    assign o_out_target = r_out.ev_target;
    assign o_last       = r_last;

endmodule

[rtl/vteq_cell.sv]
// ----------------------------------------------------------------------------
// vteq_cell
// One slot of the sorted event chain. On insert the cell keeps its event,
// takes the new event, or takes its left neighbor's event; on pop it takes
// its right neighbor's event.
// ----------------------------------------------------------------------------
module vteq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vteq_pkg::t_cell_ctrl i_ctrl,
    input  vteq_pkg::t_entry    i_new,
    input  vteq_pkg::t_entry    i_prev_entry,
    input  logic                i_prev_valid,
    input  logic                i_prev_shift,
    input  vteq_pkg::t_entry    i_next_entry,
    input  logic                i_next_valid,
    output vteq_pkg::t_entry    o_entry,
    output logic                o_valid,
    output logic                o_shift
);
    import vteq_pkg::*;

    t_entry r_entry;
    logic   r_valid;
    logic   w_later;

    // The new event goes before this one only when strictly earlier, so equal
    // times stay in the order they were scheduled.
    assign w_later = i_new.ev_time < r_entry.ev_time;
    assign o_shift = r_valid && w_later;
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.pop) begin
            r_valid <= i_next_valid;
            r_entry <= i_next_entry;
        end else if (i_ctrl.ins) begin
            if (i_prev_shift) begin
                r_valid <= 1'b1;
                r_entry <= i_prev_entry;
            end else if ((r_valid && w_later) || (!r_valid && i_prev_valid)) begin
                r_valid <= 1'b1;
                r_entry <= i_new;
            end
        end
    end

endmodule

[rtl/vteq_checker.sv]
// ----------------------------------------------------------------------------
// vteq_checker
// Port-level checks on the event queue: answer timing and delivery order.
// ----------------------------------------------------------------------------
module vteq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_kind,
    input logic [31:0] o_out_time,
    input logic        o_last
);
    import vteq_pkg::*;

    // Every accepted command gives a result in the next cycle.
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted command without a result");

    // A drain in progress delivers a result every cycle.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("drain cycle without a result");

    // Only deliveries can be followed by more results of the same command.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_DELIVERED) |-> o_last)
        else $error("single answer not marked last");

    // A delivery that is not last keeps the queue busy.
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_DELIVERED && !o_last) |-> busy)
        else $error("drain ended before the last delivery");

    // Deliveries within one drain come out in nondecreasing time.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_DELIVERED && !o_last) |=>
        (o_valid && o_kind == KIND_DELIVERED && o_out_time >= $past(o_out_time)))
        else $error("deliveries out of time order");

endmodule

bind virtual_time_event_queue vteq_checker u_vteq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_kind     (o_kind),
    .o_out_time (o_out_time),
    .o_last     (o_last)
);
